### rtl/core/dni_pkg.sv
// ----------------------------------------------------------------------------
// dni_pkg: shared types and constants of the DMA network interface registers
// Holds the register map, status and control bit positions, the operation
// codes and the command and result structures passed between the stages.
// ----------------------------------------------------------------------------
package dni_pkg;

   // Size of the tx buffer and largest accepted frame.
   localparam int unsigned MAX_FRAME_BYTES = 2048;
   localparam int unsigned TXB_AW          = $clog2(MAX_FRAME_BYTES);
   localparam logic [16:0] MAX_FRAME_W     = 17'(MAX_FRAME_BYTES);

   // Register map (offsets within the device window).
   localparam logic [4:0] OFS_CONTROL   = 5'h00;
   localparam logic [4:0] OFS_STATUS    = 5'h02;
   localparam logic [4:0] OFS_RX_LEN    = 5'h04;
   localparam logic [4:0] OFS_TX_LEN    = 5'h06;
   localparam logic [4:0] OFS_DMA_HI    = 5'h08;
   localparam logic [4:0] OFS_DMA_LO    = 5'h0A;
   localparam int unsigned OFS_MAC_FIRST = 12;
   localparam int unsigned MAC_BYTES     = 6;

   // Status and control bit positions.
   localparam int unsigned STS_RX_READY = 0;
   localparam int unsigned STS_TX_DONE  = 1;
   localparam int unsigned CTRL_IRQ_EN  = 1;
   localparam int unsigned CTRL_TX_GO   = 2;

   // Configuration register indexes.
   localparam logic CFG_IRQ_LEVEL    = 1'b0;
   localparam logic CFG_BUS_ATTACHED = 1'b1;

   // Command queue between front and back.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Operation of one request; unused request codes become OP_NONE.
   typedef enum logic [2:0] {
      OP_READ   = 3'd0,
      OP_WRITE  = 3'd1,
      OP_RX     = 3'd2,
      OP_FILL   = 3'd3,
      OP_PULL   = 3'd4,
      OP_TXREAD = 3'd5,
      OP_NONE   = 3'd6
   } op_type;

   // Classified request as it travels through the queue.
   typedef struct packed {
      op_type      op;
      logic        size_word;
      logic [4:0]  offset;
      logic [15:0] write_data;
      logic [7:0]  byte_data;
      logic [10:0] byte_index;
      logic [11:0] frame_length;
      logic [15:0] max_clip;     // max_len clipped to the frame limit
      logic        rx_ok;        // rx byte lies inside an acceptable frame
      logic        rx_last;      // rx byte is the last one of its frame
      logic        txb_ok;       // index lies inside the tx buffer
   } cmd_type;

   // One result item.
   typedef struct packed {
      logic [15:0] read_data;
      logic [2:0]  irq_out;
      logic        dma_write_valid;
      logic [31:0] dma_addr;
      logic [7:0]  dma_write_byte;
      logic        tx_request_valid;
      logic [11:0] tx_request_length;
      logic [11:0] pull_length;
      logic [7:0]  tx_byte;
   } rsp_type;

endpackage

### rtl/core/dni_front.sv
// ----------------------------------------------------------------------------
// dni_front: request classification
// Decodes the operation code and works out the range checks of rx, fill and
// pull requests so that the back end only applies the results.
// ----------------------------------------------------------------------------
module dni_front (
   input  logic [2:0]       req_func,
   input  logic             req_size_word,
   input  logic [4:0]       req_offset,
   input  logic [15:0]      req_write_data,
   input  logic [7:0]       req_byte_data,
   input  logic [10:0]      req_byte_index,
   input  logic [11:0]      req_frame_length,
   input  logic [15:0]      req_max_len,
   output dni_pkg::cmd_type cmd
);
   import dni_pkg::*;

   logic [16:0] flen_w;
   logic [16:0] idx_w;
   logic [16:0] mlen_w;

   assign flen_w = {5'b0, req_frame_length};
   assign idx_w  = {6'b0, req_byte_index};
   assign mlen_w = {1'b0, req_max_len};

   // Classify the request and precompute its range checks.
   always_comb begin
      cmd.op           = (req_func <= OP_TXREAD) ? op_type'(req_func) : OP_NONE;
      cmd.size_word    = req_size_word;
      cmd.offset       = req_offset;
      cmd.write_data   = req_write_data;
      cmd.byte_data    = req_byte_data;
      cmd.byte_index   = req_byte_index;
      cmd.frame_length = req_frame_length;
      cmd.max_clip     = (mlen_w > MAX_FRAME_W) ? MAX_FRAME_W[15:0] : req_max_len;
      cmd.rx_ok        = (flen_w <= MAX_FRAME_W) && (req_frame_length != 12'd0) &&
                         ({1'b0, req_byte_index} < req_frame_length);
      cmd.rx_last      = ({1'b0, req_byte_index} == (req_frame_length - 12'd1));
      cmd.txb_ok       = (idx_w < MAX_FRAME_W);
   end

endmodule

### rtl/core/dni_queue.sv
// ----------------------------------------------------------------------------
// dni_queue: command queue
// Short first-in first-out queue that separates the request side from the
// execution side so that each can stall on its own.
// ----------------------------------------------------------------------------
module dni_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dni_pkg::cmd_type push_cmd,
   output logic             can_push,
   input  logic             pop,
   output logic             can_pop,
   output dni_pkg::cmd_type pop_cmd
);
   import dni_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                do_push;
   logic                do_pop;

   assign can_push = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign can_pop  = (count_ff != '0);
   assign do_push  = push && can_push;
   assign do_pop   = pop && can_pop;
   assign pop_cmd  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // The fill count never exceeds the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill count above depth");

   // The fill count rises by one on a push that has no pop beside it.
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue fill count missed a push");

   // Read and write pointers agree when the queue is empty.
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("queue pointers differ while empty");

endmodule

### rtl/core/dni_back.sv
// ----------------------------------------------------------------------------
// dni_back: register file and execution
// Holds the device registers, the MAC bytes and the tx buffer, applies one classified
// command per cycle unless an untaken result stalls it, and keeps the result in an output register.
// ----------------------------------------------------------------------------
module dni_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [2:0]       csr_wr_data,
   input  logic             cmd_valid,
   input  dni_pkg::cmd_type cmd,
   output logic             cmd_take,
   output logic             rsp_valid,
   input  logic             rsp_take,
   output dni_pkg::rsp_type rsp
);
   import dni_pkg::*;

   // Byte read of the register map.
   function automatic logic [7:0] rd_byte(
      input logic [5:0]                    a,
      input logic [15:0]                   sts,
      input logic [15:0]                   rxl,
      input logic [MAC_BYTES-1:0][7:0]     mac
   );
      logic [7:0] r;
      r = 8'd0;
      for (int k = 0; k < MAC_BYTES; k++) begin
         if (a == 6'(OFS_MAC_FIRST + k)) r = mac[k];
      end
      if (a == {1'b0, OFS_STATUS})             r = sts[15:8];
      if (a == {1'b0, OFS_STATUS} + 6'd1)      r = sts[7:0];
      if (a == {1'b0, OFS_RX_LEN})             r = rxl[15:8];
      if (a == {1'b0, OFS_RX_LEN} + 6'd1)      r = rxl[7:0];
      return r;
   endfunction

   // Configuration registers.
   logic [2:0]  irq_level_ff;
   logic        bus_attached_ff;

   // Device registers.
   logic [15:0]                ctrl_ff, ctrl_in;
   logic [15:0]                status_ff, status_in;
   logic [15:0]                rx_len_ff, rx_len_in;
   logic [15:0]                tx_len_ff, tx_len_in;
   logic [31:0]                dma_ff, dma_in;
   logic [MAC_BYTES-1:0][7:0]  mac_ff, mac_in;

   // Tx buffer and its registered read data.
   logic [7:0]         txb_mem [MAX_FRAME_BYTES];
   logic [7:0]         txb_rd_ff;
   logic [TXB_AW-1:0]  txb_addr;
   logic               txb_wr;

   // Output register.
   logic     res_valid_ff;
   rsp_type  res_ff, res_in;
   logic     txb_sel_ff, txb_sel_in;

   logic        advance;
   logic [5:0]  off6;
   logic [5:0]  off6_next;
   logic [15:0] pull_len;

   assign advance   = cmd_valid && (!res_valid_ff || rsp_take);
   assign cmd_take  = advance;
   assign rsp_valid = res_valid_ff;
   assign off6      = {1'b0, cmd.offset};
   assign off6_next = off6 + 6'd1;
   assign txb_addr  = TXB_AW'(cmd.byte_index);
   assign txb_wr    = advance && (cmd.op == OP_FILL) && cmd.txb_ok;
   assign pull_len  = (tx_len_ff > cmd.max_clip) ? cmd.max_clip : tx_len_ff;

   always_comb begin
      rsp         = res_ff;
      rsp.tx_byte = txb_sel_ff ? txb_rd_ff : 8'd0;
   end

   // Next register state and result of the command at the head of the queue.
   always_comb begin
      ctrl_in    = ctrl_ff;
      status_in  = status_ff;
      rx_len_in  = rx_len_ff;
      tx_len_in  = tx_len_ff;
      dma_in     = dma_ff;
      mac_in     = mac_ff;
      res_in     = '0;
      txb_sel_in = 1'b0;
      unique case (cmd.op)
         OP_READ: begin
            if (cmd.size_word && (cmd.offset == OFS_STATUS)) begin
               res_in.read_data = status_ff;
            end else if (cmd.size_word && (cmd.offset == OFS_RX_LEN)) begin
               res_in.read_data = rx_len_ff;
            end else if (cmd.size_word) begin
               res_in.read_data = {rd_byte(off6, status_ff, rx_len_ff, mac_ff),
                                   rd_byte(off6_next, status_ff, rx_len_ff, mac_ff)};
            end else begin
               res_in.read_data = {8'd0, rd_byte(off6, status_ff, rx_len_ff, mac_ff)};
            end
         end
         OP_WRITE: begin
            if (!cmd.size_word) begin
               for (int k = 0; k < MAC_BYTES; k++) begin
                  if (off6 == 6'(OFS_MAC_FIRST + k)) mac_in[k] = cmd.write_data[7:0];
               end
            end else begin
               unique case (cmd.offset)
                  OFS_CONTROL: begin
                     ctrl_in = cmd.write_data;
                     if (cmd.write_data[CTRL_TX_GO]) begin
                        if (bus_attached_ff && ({1'b0, tx_len_ff} <= MAX_FRAME_W)) begin
                           res_in.tx_request_valid  = 1'b1;
                           res_in.tx_request_length = tx_len_ff[11:0];
                           res_in.dma_addr          = dma_ff;
                           status_in[STS_TX_DONE]   = 1'b1;
                        end
                        ctrl_in[CTRL_TX_GO] = 1'b0;
                     end
                  end
                  OFS_STATUS: status_in = status_ff & ~cmd.write_data;
                  OFS_TX_LEN: tx_len_in = cmd.write_data;
                  OFS_DMA_HI: dma_in = {cmd.write_data, dma_ff[15:0]};
                  OFS_DMA_LO: dma_in = {dma_ff[31:16], cmd.write_data};
                  default: begin
                     for (int k = 0; k < MAC_BYTES; k++) begin
                        if (off6 == 6'(OFS_MAC_FIRST + k)) begin
                           mac_in[k] = cmd.write_data[15:8];
                        end
                        if (off6_next == 6'(OFS_MAC_FIRST + k)) begin
                           mac_in[k] = cmd.write_data[7:0];
                        end
                     end
                  end
               endcase
            end
         end
         OP_RX: begin
            if (cmd.rx_ok) begin
               if (bus_attached_ff) begin
                  res_in.dma_write_valid = 1'b1;
                  res_in.dma_addr        = dma_ff + {21'd0, cmd.byte_index};
                  res_in.dma_write_byte  = cmd.byte_data;
               end
               if (cmd.rx_last) begin
                  rx_len_in               = {4'd0, cmd.frame_length};
                  status_in[STS_RX_READY] = 1'b1;
               end
            end
         end
         OP_FILL: begin
         end
         OP_PULL: begin
            if (status_ff[STS_TX_DONE]) begin
               res_in.pull_length     = pull_len[11:0];
               status_in[STS_TX_DONE] = 1'b0;
            end
         end
         OP_TXREAD: txb_sel_in = cmd.txb_ok;
         OP_NONE: begin
         end
         default: begin
         end
      endcase
      res_in.irq_out = (ctrl_in[CTRL_IRQ_EN] && status_in[STS_RX_READY]) ?
                       irq_level_ff : 3'd0;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         irq_level_ff    <= 3'd0;
         bus_attached_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CFG_IRQ_LEVEL:    irq_level_ff    <= csr_wr_data;
            CFG_BUS_ATTACHED: bus_attached_ff <= csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Device registers and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff      <= '0;
         status_ff    <= '0;
         rx_len_ff    <= '0;
         tx_len_ff    <= '0;
         dma_ff       <= '0;
         mac_ff       <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            ctrl_ff   <= ctrl_in;
            status_ff <= status_in;
            rx_len_ff <= rx_len_in;
            tx_len_ff <= tx_len_in;
            dma_ff    <= dma_in;
            mac_ff    <= mac_in;
         end
         if (advance) begin
            res_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            res_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff     <= res_in;
         txb_sel_ff <= txb_sel_in;
      end
   end

   // Tx buffer write and registered read.
   always_ff @(posedge clock) begin
      if (txb_wr) begin
         txb_mem[txb_addr] <= cmd.byte_data;
      end
      if (advance) begin
         txb_rd_ff <= txb_mem[txb_addr];
      end
   end

   // A tx request always leaves tx-done set.
   a_tx_done: assert property (@(posedge clock) disable iff (reset)
      (advance && res_in.tx_request_valid) |=> status_ff[STS_TX_DONE])
      else $error("tx request without tx-done");

   // The last byte of an accepted frame leaves rx-ready set.
   a_rx_ready: assert property (@(posedge clock) disable iff (reset)
      (advance && (cmd.op == OP_RX) && cmd.rx_ok && cmd.rx_last)
      |=> status_ff[STS_RX_READY])
      else $error("frame end without rx-ready");

   // A pending interrupt in the result matches the register state.
   a_irq_state: assert property (@(posedge clock) disable iff (reset)
      (res_valid_ff && (res_ff.irq_out != 3'd0))
      |-> (ctrl_ff[CTRL_IRQ_EN] && status_ff[STS_RX_READY]))
      else $error("interrupt reported without enable and rx-ready");

   // A waiting result holds while the consumer stalls.
   a_res_hold: assert property (@(posedge clock) disable iff (reset)
      (res_valid_ff && !rsp_take) |=> (res_valid_ff && $stable(res_ff)))
      else $error("result changed while stalled");

endmodule

### rtl/core/dma_network_interface_regs.sv
// ----------------------------------------------------------------------------
// dma_network_interface_regs: register block of a DMA network interface
// A result passes through the command queue and then the output register before
// it is offered. Throughput: one request per cycle while the result channel does
// not stall; an untaken result holds the back end and the queue then fills.
// A two-entry queue keeps requests flowing while a result waits to be taken.
// Reset (synchronous) clears registers, MAC bytes, configuration and queue;
// the tx buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module dma_network_interface_regs (
   input  logic        clock,
   input  logic        reset,
   // Configuration port.
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [2:0]  csr_wr_data,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // From bit 0: func.
   input  logic [2:0]  req_tuser,
   // From bit 0: size_word, offset, write_data, byte_data, byte_index,
   // frame_length, max_len, zero fill.
   input  logic [71:0] req_tdata,
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // From bit 0: read_data, irq_out, dma_write_valid, dma_addr, dma_write_byte,
   // tx_request_valid, tx_request_length, pull_length, tx_byte, zero fill.
   output logic [95:0] rsp_tdata
);
   import dni_pkg::*;

   cmd_type front_cmd;
   cmd_type head_cmd;
   logic    q_can_push;
   logic    q_can_pop;
   logic    q_pop;
   rsp_type rsp;

   // Request classification.
   dni_front u_front (
      .req_func         (req_tuser),
      .req_size_word    (req_tdata[0]),
      .req_offset       (req_tdata[5:1]),
      .req_write_data   (req_tdata[21:6]),
      .req_byte_data    (req_tdata[29:22]),
      .req_byte_index   (req_tdata[40:30]),
      .req_frame_length (req_tdata[52:41]),
      .req_max_len      (req_tdata[68:53]),
      .cmd              (front_cmd)
   );

   // Command queue.
   dni_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_tvalid),
      .push_cmd (front_cmd),
      .can_push (q_can_push),
      .pop      (q_pop),
      .can_pop  (q_can_pop),
      .pop_cmd  (head_cmd)
   );

   assign req_tready = q_can_push;

   // Execution and result register.
   dni_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd_valid   (q_can_pop),
      .cmd         (head_cmd),
      .cmd_take    (q_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_take    (rsp_tready),
      .rsp         (rsp)
   );

   // Pack the result transfer.
   assign rsp_tdata = {3'b000, rsp.tx_byte, rsp.pull_length, rsp.tx_request_length,
                       rsp.tx_request_valid, rsp.dma_write_byte, rsp.dma_addr,
                       rsp.dma_write_valid, rsp.irq_out, rsp.read_data};

endmodule

### verif/tb_dma_network_interface_regs.sv
// ----------------------------------------------------------------------------
// tb_dma_network_interface_regs: self-checking bench of the NIC register block
// Requests come from a queue that the stimulus process fills: a directed
// opening, then eight phases of random register, rx, tx and pull traffic under
// changing interrupt level, bus presence and idling. Each accepted request
// transfer runs through a local model of the registers, and every result
// transfer is compared field by field against the oldest expected response.
// ----------------------------------------------------------------------------
module tb_dma_network_interface_regs;

   import dni_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned PHASE_ITEMS  = 240;
   localparam logic [2:0]  FUNC_SPARE   = 3'd7;

   // Request payload as it travels in req_tdata, lowest field last.
   typedef struct packed {
      logic [2:0]  pad;
      logic [15:0] max_len;
      logic [11:0] frame_length;
      logic [10:0] byte_index;
      logic [7:0]  byte_data;
      logic [15:0] write_data;
      logic [4:0]  offset;
      logic        size_word;
   } nic_req_t;

   typedef struct packed {
      logic [2:0] func;
      nic_req_t   body;
   } nic_item_t;

   // Response as it travels in rsp_tdata, lowest field last.
   typedef struct packed {
      logic [2:0]  pad;
      logic [7:0]  tx_byte;
      logic [11:0] pull_length;
      logic [11:0] tx_request_length;
      logic        tx_request_valid;
      logic [7:0]  dma_write_byte;
      logic [31:0] dma_addr;
      logic        dma_write_valid;
      logic [2:0]  irq_out;
      logic [15:0] read_data;
   } nic_rsp_t;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic        csr_index   = 1'b0;
   logic [2:0]  csr_wr_data = 3'd0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser   = 3'd0;
   logic [71:0] req_tdata   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [95:0] rsp_tdata;

   dma_network_interface_regs dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),     // func
      .req_tdata   (req_tdata),     // size_word, offset, write_data, byte_data,
                                    // byte_index, frame_length, max_len, zero fill
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)      // read_data, irq_out, dma_write_valid, dma_addr,
                                    // dma_write_byte, tx_request_valid,
                                    // tx_request_length, pull_length, tx_byte, zero fill
   );

   always #2 clock = ~clock;

   // Local copy of the register state and configuration.
   logic [15:0] ctl_q, sts_q, rxlen_q, txlen_q;
   logic [31:0] dmaadr_q;
   logic [7:0]  mac_q [MAC_BYTES];
   logic [7:0]  txbuf_q [MAX_FRAME_BYTES];
   logic [2:0]  cfg_irq_level;
   logic        cfg_bus;

   nic_item_t   pending [$];        // requests waiting for the driver
   nic_rsp_t    awaiting_rsp [$];   // predicted responses in transfer order
   nic_item_t   drv_item;
   logic        req_taken = 1'b0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          mismatches = 0;
   int          gen_count = 0;
   int unsigned cycle_count = 0;

   // Tx buffer entries that the stimulus has already filled.
   bit          fill_done [MAX_FRAME_BYTES];
   int          fill_list [$];

   initial begin
      ctl_q = '0;
      sts_q = '0;
      rxlen_q = '0;
      txlen_q = '0;
      dmaadr_q = '0;
      cfg_irq_level = '0;
      cfg_bus = 1'b0;
      for (int i = 0; i < MAC_BYTES; i++) mac_q[i] = '0;
   end

   // Byte view of the register window.
   function automatic logic [7:0] reg_byte(int unsigned off);
      if (off >= OFS_MAC_FIRST && off < OFS_MAC_FIRST + MAC_BYTES)
         return mac_q[off - OFS_MAC_FIRST];
      case (off)
         OFS_STATUS:     return sts_q[15:8];
         OFS_STATUS + 1: return sts_q[7:0];
         OFS_RX_LEN:     return rxlen_q[15:8];
         OFS_RX_LEN + 1: return rxlen_q[7:0];
         default:        return 8'h00;
      endcase
   endfunction

   function automatic void mac_write(int unsigned off, logic [7:0] val);
      if (off >= OFS_MAC_FIRST && off < OFS_MAC_FIRST + MAC_BYTES)
         mac_q[off - OFS_MAC_FIRST] = val;
   endfunction

   // Apply one request to the register state and return its response.
   function automatic nic_rsp_t nic_response(nic_item_t it);
      nic_rsp_t    r;
      nic_req_t    b;
      int unsigned off;
      int unsigned clip;
      r = '0;
      b = it.body;
      off = b.offset;
      case (op_type'(it.func))
         OP_READ: begin
            if (!b.size_word) r.read_data = {8'h00, reg_byte(off)};
            else if (b.offset == OFS_STATUS) r.read_data = sts_q;
            else if (b.offset == OFS_RX_LEN) r.read_data = rxlen_q;
            else r.read_data = {reg_byte(off), reg_byte(off + 1)};
         end
         OP_WRITE: begin
            if (!b.size_word) mac_write(off, b.write_data[7:0]);
            else begin
               case (b.offset)
                  OFS_CONTROL: begin
                     ctl_q = b.write_data;
                     if (b.write_data[CTRL_TX_GO]) begin
                        // A start only goes out with a bus and a length that fits.
                        if (cfg_bus && txlen_q <= MAX_FRAME_BYTES) begin
                           r.tx_request_valid = 1'b1;
                           r.tx_request_length = txlen_q[11:0];
                           r.dma_addr = dmaadr_q;
                           sts_q[STS_TX_DONE] = 1'b1;
                        end
                        ctl_q[CTRL_TX_GO] = 1'b0;
                     end
                  end
                  OFS_STATUS: sts_q = sts_q & ~b.write_data;
                  OFS_TX_LEN: txlen_q = b.write_data;
                  OFS_DMA_HI: dmaadr_q[31:16] = b.write_data;
                  OFS_DMA_LO: dmaadr_q[15:0] = b.write_data;
                  default: begin
                     mac_write(off, b.write_data[15:8]);
                     mac_write(off + 1, b.write_data[7:0]);
                  end
               endcase
            end
         end
         OP_RX: begin
            if (b.frame_length <= MAX_FRAME_BYTES && b.frame_length != 0 &&
                b.byte_index < b.frame_length) begin
               if (cfg_bus) begin
                  r.dma_write_valid = 1'b1;
                  r.dma_addr = dmaadr_q + 32'(b.byte_index);
                  r.dma_write_byte = b.byte_data;
               end
               if (12'(b.byte_index) == b.frame_length - 12'd1) begin
                  rxlen_q = 16'(b.frame_length);
                  sts_q[STS_RX_READY] = 1'b1;
               end
            end
         end
         OP_FILL: txbuf_q[b.byte_index] = b.byte_data;
         OP_PULL: begin
            if (sts_q[STS_TX_DONE]) begin
               clip = txlen_q;
               if (clip > b.max_len) clip = b.max_len;
               if (clip > MAX_FRAME_BYTES) clip = MAX_FRAME_BYTES;
               r.pull_length = 12'(clip);
               sts_q[STS_TX_DONE] = 1'b0;
            end
         end
         OP_TXREAD: r.tx_byte = txbuf_q[b.byte_index];
         default: ;
      endcase
      r.irq_out = (ctl_q[CTRL_IRQ_EN] && sts_q[STS_RX_READY]) ? cfg_irq_level : 3'd0;
      return r;
   endfunction

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Monitor: check result transfers, then predict accepted request transfers.
   always @(posedge clock) begin
      nic_rsp_t  got, want;
      nic_item_t seen;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = nic_rsp_t'(rsp_tdata);
            if (awaiting_rsp.size() == 0) begin
               $error("result transfer with no request outstanding: 0x%0h", rsp_tdata);
               mismatches++;
            end else begin
               want = awaiting_rsp.pop_front();
               check_field("read_data", want.read_data, got.read_data);
               check_field("irq_out", want.irq_out, got.irq_out);
               check_field("dma_write_valid", want.dma_write_valid, got.dma_write_valid);
               check_field("dma_addr", want.dma_addr, got.dma_addr);
               check_field("dma_write_byte", want.dma_write_byte, got.dma_write_byte);
               check_field("tx_request_valid", want.tx_request_valid,
                           got.tx_request_valid);
               check_field("tx_request_length", want.tx_request_length,
                           got.tx_request_length);
               check_field("pull_length", want.pull_length, got.pull_length);
               check_field("tx_byte", want.tx_byte, got.tx_byte);
            end
         end
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            seen.func = req_tuser;
            seen.body = nic_req_t'(req_tdata);
            awaiting_rsp.push_back(nic_response(seen));
         end
      end
   end

   // Driver: present the next request once the current one has been taken.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            drv_item = pending.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= drv_item.func;
            req_tdata <= drv_item.body;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Request with random contents in every field the operation ignores.
   function automatic nic_req_t noise_body();
      nic_req_t b;
      b.pad = '0;
      b.max_len = 16'($urandom_range(65535));
      b.frame_length = 12'($urandom_range(4095));
      b.byte_index = 11'($urandom_range(2047));
      b.byte_data = 8'($urandom_range(255));
      b.write_data = 16'($urandom_range(65535));
      b.offset = 5'($urandom_range(31));
      b.size_word = 1'($urandom_range(1));
      return b;
   endfunction

   task automatic push_item(logic [2:0] func, nic_req_t b);
      nic_item_t it;
      it.func = func;
      it.body = b;
      pending.push_back(it);
      gen_count++;
   endtask

   task automatic push_read(logic word, logic [4:0] off);
      nic_req_t b;
      b = noise_body();
      b.size_word = word;
      b.offset = off;
      push_item(OP_READ, b);
   endtask

   task automatic push_write(logic word, logic [4:0] off, logic [15:0] val);
      nic_req_t b;
      b = noise_body();
      b.size_word = word;
      b.offset = off;
      b.write_data = val;
      push_item(OP_WRITE, b);
   endtask

   task automatic push_rx(logic [11:0] flen, logic [10:0] idx, logic [7:0] val);
      nic_req_t b;
      b = noise_body();
      b.frame_length = flen;
      b.byte_index = idx;
      b.byte_data = val;
      push_item(OP_RX, b);
   endtask

   task automatic push_fill(logic [10:0] idx, logic [7:0] val);
      nic_req_t b;
      b = noise_body();
      b.byte_index = idx;
      b.byte_data = val;
      if (!fill_done[idx]) fill_list.push_back(idx);
      fill_done[idx] = 1'b1;
      push_item(OP_FILL, b);
   endtask

   // Buffer reads only ever target entries that a fill has written.
   task automatic push_txread(logic [10:0] idx);
      nic_req_t b;
      b = noise_body();
      b.byte_index = idx;
      push_item(OP_TXREAD, b);
   endtask

   task automatic push_pull(logic [15:0] mlen);
      nic_req_t b;
      b = noise_body();
      b.max_len = mlen;
      push_item(OP_PULL, b);
   endtask

   function automatic logic [4:0] pick_offset();
      return ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(19));
   endfunction

   // One random scenario: a short well-formed sequence or a single item.
   task automatic add_scenario();
      int          sel, flen, len, idx, k;
      logic [15:0] val;
      sel = $urandom_range(99);
      if (sel < 25) begin
         k = $urandom_range(19);
         if (k < 14) begin
            // Complete short frame.
            flen = $urandom_range(1, 8);
            for (int j = 0; j < flen; j++) push_rx(12'(flen), 11'(j), 8'($urandom_range(255)));
         end else if (k < 17) begin
            // Tail of a long frame, up to the largest legal length.
            flen = ($urandom_range(3) == 0) ? MAX_FRAME_BYTES : $urandom_range(9, 2048);
            for (int j = $urandom_range(2); j >= 0; j--)
               push_rx(12'(flen), 11'(flen - 1 - j), 8'($urandom_range(255)));
         end else if (k == 17) begin
            push_rx(12'd0, 11'($urandom_range(2047)), 8'($urandom_range(255)));
         end else if (k == 18) begin
            flen = $urandom_range(MAX_FRAME_BYTES + 1, 4095);
            push_rx(12'(flen), 11'($urandom_range(2047)), 8'($urandom_range(255)));
         end else begin
            flen = $urandom_range(1, 2047);
            push_rx(12'(flen), 11'($urandom_range(flen, 2047)), 8'($urandom_range(255)));
         end
      end else if (sel < 40) begin
         // Transmit: length, optional address, start, buffer fill, pull.
         k = $urandom_range(9);
         if (k < 7) len = $urandom_range(6);
         else if (k == 7) len = MAX_FRAME_BYTES + $urandom_range(1);
         else len = $urandom_range(65535);
         push_write(1'b1, OFS_TX_LEN, 16'(len));
         if ($urandom_range(1)) begin
            push_write(1'b1, OFS_DMA_HI, 16'($urandom_range(65535)));
            push_write(1'b1, OFS_DMA_LO, 16'($urandom_range(65535)));
         end
         val = 16'($urandom_range(65535));
         val[CTRL_TX_GO] = 1'b1;
         push_write(1'b1, OFS_CONTROL, val);
         if (len <= 6) begin
            for (int j = 0; j < len; j++) push_fill(11'(j), 8'($urandom_range(255)));
            for (int j = 0; j < len; j++) if ($urandom_range(1)) push_txread(11'(j));
         end
         k = $urandom_range(3);
         if (k == 0) push_pull(16'hFFFF);
         else if (k == 1) push_pull(16'($urandom_range(8)));
         else if (k == 2) push_pull(16'($urandom_range(65535)));
      end else if (sel < 55) begin
         push_read(1'($urandom_range(1)), pick_offset());
      end else if (sel < 70) begin
         k = $urandom_range(5);
         val = 16'($urandom_range(65535));
         if (k == 0) push_write(1'b1, OFS_CONTROL, val);
         else if (k == 1) push_write(1'b1, OFS_STATUS, val);
         else if (k == 2) push_write(1'b1, 5'($urandom_range(OFS_MAC_FIRST, 17)), val);
         else push_write(1'($urandom_range(1)), pick_offset(), val);
      end else if (sel < 78) begin
         push_pull(16'($urandom_range(65535)));
      end else if (sel < 86) begin
         idx = ($urandom_range(1)) ? $urandom_range(15) : $urandom_range(2047);
         push_fill(11'(idx), 8'($urandom_range(255)));
      end else if (sel < 94) begin
         if (fill_list.size() == 0) push_fill(11'($urandom_range(2047)), 8'($urandom_range(255)));
         else push_txread(11'(fill_list[$urandom_range(fill_list.size() - 1)]));
      end else begin
         push_item(($urandom_range(1)) ? 3'(OP_NONE) : FUNC_SPARE, noise_body());
      end
   endtask

   // Hold off until every request has gone through and every result is back.
   task automatic wait_idle();
      while (pending.size() != 0 || req_tvalid || awaiting_rsp.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(logic [2:0] level, logic bus);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CFG_IRQ_LEVEL;
      csr_wr_data <= level;
      @(negedge clock);
      csr_index <= CFG_BUS_ATTACHED;
      csr_wr_data <= {2'b00, bus};
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cfg_irq_level = level;
      cfg_bus = bus;
   endtask

   // Stimulus.
   initial begin
      logic [2:0] levels [8];
      logic       buses [8];
      int         phase_end;
      levels = '{3'd0, 3'd7, 3'd3, 3'd5, 3'd1, 3'd7, 3'd0, 3'd6};
      buses = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      set_config(3'd7, 1'b1);

      // Directed opening: extremes, every operation and the corner cases.
      push_read(1'b1, OFS_STATUS);
      push_write(1'b1, OFS_TX_LEN, 16'(MAX_FRAME_BYTES));
      push_write(1'b1, OFS_DMA_HI, 16'hFFFF);
      push_write(1'b1, OFS_DMA_LO, 16'hFFFF);
      push_write(1'b1, OFS_CONTROL, 16'h0006);
      push_fill(11'd0, 8'hFF);
      push_fill(11'd2047, 8'hA5);
      push_txread(11'd2047);
      push_txread(11'd0);
      push_pull(16'hFFFF);
      push_pull(16'hFFFF);
      push_rx(12'd1, 11'd0, 8'hFF);
      push_rx(12'(MAX_FRAME_BYTES), 11'd2047, 8'h5A);
      push_rx(12'(MAX_FRAME_BYTES + 1), 11'd0, 8'h11);
      push_rx(12'd0, 11'd0, 8'h22);
      push_rx(12'd5, 11'd7, 8'h33);
      push_read(1'b1, OFS_RX_LEN);
      push_read(1'b0, 5'(OFS_STATUS + 1));
      push_write(1'b1, OFS_STATUS, 16'hFFFF);
      push_write(1'b1, OFS_TX_LEN, 16'(MAX_FRAME_BYTES + 1));
      push_write(1'b1, OFS_CONTROL, 16'hFFFF);
      push_write(1'b1, 5'(OFS_MAC_FIRST + MAC_BYTES - 1), 16'hBEEF);
      push_write(1'b0, 5'(OFS_MAC_FIRST), 16'h00C3);
      push_read(1'b1, 5'(OFS_MAC_FIRST + MAC_BYTES - 2));
      push_read(1'b1, 5'd31);
      push_item(OP_NONE, noise_body());
      push_item(FUNC_SPARE, noise_body());
      wait_idle();

      // Random phases, each under its own configuration and idling.
      for (int ph = 0; ph < 8; ph++) begin
         set_config(levels[ph], buses[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 55; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 55; end
            default: begin send_idle_pct = 27; stall_pct = 27; end
         endcase
         phase_end = gen_count + PHASE_ITEMS;
         while (gen_count < phase_end - PHASE_ITEMS / 2) add_scenario();
         // Let the pipeline drain completely halfway through the phase.
         wait_idle();
         while (gen_count < phase_end) add_scenario();
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/dni_pkg.sv
rtl/core/dni_front.sv
rtl/core/dni_queue.sv
rtl/core/dni_back.sv
rtl/core/dma_network_interface_regs.sv
verif/tb_dma_network_interface_regs.sv
